// ===== hw/rtl/fdpc_pkg.sv =====
package fdpc_pkg;

	typedef struct packed {
		logic        opcode;
		logic [35:0] dividend;
		logic [31:0] divisor;
	} in_item_t;

	typedef struct packed {
		logic [17:0] p1_word;
		logic [19:0] p2_word;
		logic [19:0] p3_word;
		logic        integer_mode;
		logic        divide_by_four;
	} out_item_t;

	localparam int unsigned DivWidth = 36;

	// Commands from the controller to the datapath.
	typedef enum logic [2:0] {
		CMD_IDLE,
		CMD_LOAD,
		CMD_DIV_START,
		CMD_DIV_STEP,
		CMD_QUOT_TAKE,
		CMD_CF_PREP,
		CMD_CF_UPDATE,
		CMD_FINISH
	} cmd_t;

	// Division operand selection.
	typedef enum logic [1:0] {
		DSEL_MAIN,
		DSEL_CF,
		DSEL_P1
	} dsel_t;

	typedef struct packed {
		cmd_t  cmd;
		dsel_t dsel;
	} ctrl_t;

	typedef struct packed {
		logic div_last;
		logic need_cf;
		logic cf_done;
		logic cf_break;
		logic need_p1;
	} stat_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MAIN_START,
		ST_MAIN_RUN,
		ST_CF_CHECK,
		ST_CF_START,
		ST_CF_RUN,
		ST_CF_PREP,
		ST_CF_UPDATE,
		ST_P_START,
		ST_P_RUN,
		ST_FINISH,
		ST_OUT
	} state_t;

endpackage

// ===== hw/rtl/fdpc_ctrl.sv =====
module fdpc_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	output logic            out_valid,
	input  logic            out_stall,
	input  fdpc_pkg::stat_t stat,
	output fdpc_pkg::ctrl_t ctrl
);
	import fdpc_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ctrl.cmd  = CMD_IDLE;
		ctrl.dsel = DSEL_MAIN;
		in_stall  = 1'b1;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					ctrl.cmd = CMD_LOAD;
					state_d  = ST_MAIN_START;
				end
			end
			ST_MAIN_START: begin
				ctrl.cmd = CMD_DIV_START;
				state_d  = ST_MAIN_RUN;
			end
			ST_MAIN_RUN: begin
				ctrl.cmd = CMD_DIV_STEP;
				if (stat.div_last) state_d = ST_CF_CHECK;
			end
			ST_CF_CHECK: begin
				ctrl.cmd = CMD_QUOT_TAKE;
				state_d  = stat.need_cf ? ST_CF_START : ST_P_START;
			end
			ST_CF_START: begin
				ctrl.dsel = DSEL_CF;
				if (stat.cf_done) begin
					state_d = ST_P_START;
				end else begin
					ctrl.cmd = CMD_DIV_START;
					state_d  = ST_CF_RUN;
				end
			end
			ST_CF_RUN: begin
				ctrl.dsel = DSEL_CF;
				ctrl.cmd  = CMD_DIV_STEP;
				if (stat.div_last) state_d = ST_CF_PREP;
			end
			ST_CF_PREP: begin
				ctrl.cmd = CMD_CF_PREP;
				state_d  = ST_CF_UPDATE;
			end
			ST_CF_UPDATE: begin
				if (stat.cf_break) begin
					state_d = ST_P_START;
				end else begin
					ctrl.cmd = CMD_CF_UPDATE;
					state_d  = ST_CF_START;
				end
			end
			ST_P_START: begin
				ctrl.dsel = DSEL_P1;
				if (stat.need_p1) begin
					ctrl.cmd = CMD_DIV_START;
					state_d  = ST_P_RUN;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_P_RUN: begin
				ctrl.dsel = DSEL_P1;
				ctrl.cmd  = CMD_DIV_STEP;
				if (stat.div_last) state_d = ST_FINISH;
			end
			ST_FINISH: begin
				ctrl.cmd = CMD_FINISH;
				state_d  = ST_OUT;
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (!out_stall) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ===== hw/rtl/fdpc_dp.sv =====
module fdpc_dp #(
	parameter int unsigned DENOM_BITS = 20
) (
	input  logic                clk,
	input  fdpc_pkg::in_item_t  in_item,
	input  fdpc_pkg::ctrl_t     ctrl,
	output fdpc_pkg::stat_t     stat,
	output fdpc_pkg::out_item_t out_item
);
	import fdpc_pkg::*;

	localparam logic [31:0] MaxDen = 32'((64'd1 << DENOM_BITS) - 64'd1);
	localparam int unsigned CntW = $clog2(DivWidth + 1);

	logic        op_q;
	logic [35:0] dvd_q;
	logic [31:0] quo_q, num_q, den_q;
	logic [31:0] top_q, bot_q, pa_q, qa_q, pb_q, qb_q;
	logic [31:0] qn_q, pn_q;
	logic [31:0] rem_q, dq_q;
	logic [35:0] dquo_q;
	logic [31:0] dsor_q;
	logic [CntW-1:0] cnt_q;
	logic [31:0] p1_q, p2_q, p3_q;
	logic        by4_q;

	// restoring division, one quotient bit per cycle
	logic [35:0] d_num;
	logic [31:0] d_den;
	logic [32:0] trial;
	logic [32:0] sh;

	logic [31:0] n7;
	logic [31:0] fin_den;
	logic        by4_c;

	always_comb begin
		unique case (ctrl.dsel)
			DSEL_MAIN: begin
				d_num = dvd_q;
				d_den = den_q;
			end
			DSEL_CF: begin
				d_num = {4'd0, top_q};
				d_den = bot_q;
			end
			DSEL_P1: begin
				d_num = {4'd0, n7};
				d_den = fin_den;
			end
			default: begin
				d_num = dvd_q;
				d_den = den_q;
			end
		endcase
	end

	assign sh    = {rem_q, dquo_q[35]};
	assign trial = sh - {1'b0, dsor_q};
	assign n7    = {num_q[24:0], 7'd0};
	assign fin_den = (den_q == 32'd0) ? 32'd1 : den_q;
	assign by4_c = op_q && (quo_q == 32'd4);

	assign stat.div_last = (cnt_q == CntW'(1));
	assign stat.need_cf  = (den_q > MaxDen);
	assign stat.cf_done  = (bot_q == 32'd0);
	assign stat.cf_break = (qn_q > MaxDen);
	assign stat.need_p1  = !by4_c && (n7 != 32'd0);

	always_ff @(posedge clk) begin
		unique case (ctrl.cmd)
			CMD_LOAD: begin
				op_q  <= in_item.opcode;
				dvd_q <= in_item.dividend;
				den_q <= (in_item.divisor == 32'd0) ? 32'd1 : in_item.divisor;
			end
			CMD_DIV_START: begin
				dquo_q <= d_num;
				dsor_q <= d_den;
				rem_q  <= 32'd0;
				cnt_q  <= CntW'(DivWidth);
			end
			CMD_DIV_STEP: begin
				if (!trial[32]) begin
					rem_q  <= trial[31:0];
					dquo_q <= {dquo_q[34:0], 1'b1};
				end else begin
					rem_q  <= sh[31:0];
					dquo_q <= {dquo_q[34:0], 1'b0};
				end
				cnt_q <= cnt_q - CntW'(1);
			end
			CMD_QUOT_TAKE: begin
				quo_q <= dquo_q[31:0];
				top_q <= rem_q;
				bot_q <= den_q;
				pa_q  <= 32'd0;
				qa_q  <= 32'd1;
				pb_q  <= 32'd1;
				qb_q  <= 32'd0;
				if (den_q > MaxDen) begin
					// approximation ends at the last accepted convergent
					num_q <= 32'd1;
					den_q <= 32'd0;
				end else begin
					num_q <= rem_q;
				end
			end
			CMD_CF_PREP: begin
				dq_q  <= rem_q;
				qn_q  <= qa_q + dquo_q[31:0] * qb_q;
				pn_q  <= pa_q + dquo_q[31:0] * pb_q;
			end
			CMD_CF_UPDATE: begin
				pa_q  <= pb_q;
				qa_q  <= qb_q;
				pb_q  <= pn_q;
				qb_q  <= qn_q;
				num_q <= pn_q;
				den_q <= qn_q;
				top_q <= bot_q;
				bot_q <= dq_q;
			end
			CMD_FINISH: begin
				by4_q <= by4_c;
				if (by4_c) begin
					p1_q <= 32'd0;
					p2_q <= 32'd0;
					p3_q <= 32'd1;
				end else if (n7 != 32'd0) begin
					p1_q <= {quo_q[24:0], 7'd0} - 32'd512 + dquo_q[31:0];
					p2_q <= rem_q;
					p3_q <= fin_den;
				end else begin
					p1_q <= {quo_q[24:0], 7'd0} - 32'd512;
					p2_q <= 32'd0;
					p3_q <= 32'd1;
				end
			end
			default: ;
		endcase
	end

	assign out_item.p1_word        = p1_q[17:0];
	assign out_item.p2_word        = p2_q[19:0];
	assign out_item.p3_word        = p3_q[19:0];
	assign out_item.integer_mode   = (num_q == 32'd0);
	assign out_item.divide_by_four = by4_q;

endmodule

// ===== hw/rtl/fractional_divider_parameter_calc_unit.sv =====
// Sequencing: a divisor within range takes a main divide and a parameter divide
//   (the parameter divide is skipped when the scaled numerator is zero or
//   divide-by-four applies); a wide divisor adds a continued-fraction divide per
//   step. One shared 36-step restoring divider performs every divide.
// Throughput: one item at a time; the next item is taken in the cycle after
//   the result transfer completes.
// Reset: arst_n asynchronous, active low; controller returns to idle.
module fractional_divider_parameter_calc_unit #(
	parameter int unsigned DENOM_BITS = 20
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  fdpc_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output fdpc_pkg::out_item_t out_data
);
	import fdpc_pkg::*;

	ctrl_t ctrl;
	stat_t stat;

	// sequencer: load, main divide, fraction limiting, parameter divide
	fdpc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.ctrl      (ctrl)
	);

	// shared divider, convergent registers and result registers
	fdpc_dp #(.DENOM_BITS(DENOM_BITS)) u_dp (
		.clk      (clk),
		.in_item  (in_data),
		.ctrl     (ctrl),
		.stat     (stat),
		.out_item (out_data)
	);

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb;
	import fdpc_pkg::*;

	localparam int unsigned DENOM_BITS = 20;
	localparam logic [31:0] MAX_DEN = (32'd1 << DENOM_BITS) - 32'd1;
	localparam logic OP_FEEDBACK = 1'b0;
	localparam logic OP_OUTPUT = 1'b1;
	localparam int unsigned WATCHDOG_LIMIT = 20000;
	localparam int unsigned RANDOM_ITEMS = 480;

	// Golden divider-parameter calculation for one ratio.
	function automatic out_item_t calc_divider_params(in_item_t it);
		out_item_t r;
		logic [35:0] dvs;
		logic [35:0] quo36;
		logic [31:0] quo, num, den, top, bot, pa, qa, pb, qb, a, rem, qn, pn, n7, p1, p2, p3;
		logic by4;
		logic run;
		dvs = {4'd0, it.divisor};
		if (dvs == 36'd0)
			dvs = 36'd1;
		quo36 = it.dividend / dvs;
		quo = quo36[31:0];
		num = 32'(it.dividend % dvs);
		den = dvs[31:0];
		// Best rational approximation when the denominator is too wide.
		if (den > MAX_DEN) begin
			top = num;
			bot = den;
			pa = 0;
			qa = 1;
			pb = 1;
			qb = 0;
			run = 1'b1;
			while (run && bot != 0) begin
				a = top / bot;
				rem = top % bot;
				qn = qa + a * qb;
				if (qn > MAX_DEN) begin
					run = 1'b0;
				end else begin
					pn = pa + a * pb;
					pa = pb;
					qa = qb;
					pb = pn;
					qb = qn;
					top = bot;
					bot = rem;
				end
			end
			num = pb;
			den = qb;
		end
		if (den == 0)
			den = 1;
		p1 = 0;
		p2 = 0;
		p3 = 1;
		by4 = 1'b0;
		if (it.opcode == OP_OUTPUT && quo == 32'd4) begin
			by4 = 1'b1;
		end else begin
			n7 = num << 7;
			p1 = (quo << 7) - 32'd512;
			if (n7 != 0) begin
				p1 += n7 / den;
				p2 = n7 % den;
				p3 = den;
			end
		end
		r.p1_word = p1[17:0];
		r.p2_word = p2[19:0];
		r.p3_word = p3[19:0];
		r.integer_mode = (num == 0);
		r.divide_by_four = by4;
		return r;
	endfunction

	int unsigned mismatch_count = 0;

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		mismatch_count++;
	endtask

	// Scoreboard: holds expected parameter sets in transfer order.
	class param_scoreboard;
		out_item_t pending_params[$];

		function void note_input(in_item_t it);
			pending_params.push_back(calc_divider_params(it));
		endfunction

		task check_result(out_item_t got);
			out_item_t want;
			if (pending_params.size() == 0) begin
				report_mismatch("unexpected result", 64'(got), 64'd0);
			end else begin
				want = pending_params.pop_front();
				if (got.p1_word !== want.p1_word)
					report_mismatch("p1_word", 64'(got.p1_word), 64'(want.p1_word));
				if (got.p2_word !== want.p2_word)
					report_mismatch("p2_word", 64'(got.p2_word), 64'(want.p2_word));
				if (got.p3_word !== want.p3_word)
					report_mismatch("p3_word", 64'(got.p3_word), 64'(want.p3_word));
				if (got.integer_mode !== want.integer_mode)
					report_mismatch("integer_mode", 64'(got.integer_mode),
						64'(want.integer_mode));
				if (got.divide_by_four !== want.divide_by_four)
					report_mismatch("divide_by_four", 64'(got.divide_by_four),
						64'(want.divide_by_four));
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_data;

	// Idle percentages per phase; hold_off forces a long receiver stall.
	int unsigned send_idle_pct = 24;
	int unsigned recv_idle_pct = 65;
	bit hold_off = 1'b0;
	int unsigned idle_cycles = 0;

	param_scoreboard sb = new();

	fractional_divider_parameter_calc_unit #(.DENOM_BITS(DENOM_BITS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Offer one item, with random idle before it; returns once transferred.
	// Valid stays high after a transfer unless idle cycles follow.
	task automatic send_item(logic op, logic [35:0] dvd, logic [31:0] dvs);
		in_item_t it;
		int unsigned idle_n;
		it.opcode = op;
		it.dividend = dvd;
		it.divisor = dvs;
		idle_n = 0;
		while ($urandom_range(99) < send_idle_pct)
			idle_n++;
		if (idle_n != 0) begin
			in_valid <= 1'b0;
			repeat (idle_n)
				@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do
			@(posedge clk);
		while (in_stall);
		// Accepted at this edge; note it before the result can show up.
		sb.note_input(it);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_params.size() != 0)
			@(posedge clk);
	endtask

	// Random ratio: some narrow or tiny divisors, mostly wide ones for the
	// continued-fraction path, some tuned to land near quotient four.
	task automatic send_random();
		logic [35:0] dvd;
		logic [31:0] dvs;
		logic [35:0] w;
		w = 36'({$urandom, $urandom});
		case ($urandom_range(5))
			0: begin
				dvs = $urandom_range(1, 32'hFFFFF);
				dvd = w;
			end
			1: begin
				dvs = $urandom;
				dvd = w;
			end
			2: begin
				dvs = $urandom_range(32'h100000, 32'hFFFFFFF);
				dvd = 36'(dvs) * 36'($urandom_range(1, 8)) + 36'($urandom_range(0, 3));
			end
			3: begin
				dvs = $urandom_range(1, 32'h3FFFFFFF);
				dvd = 36'(dvs) * 36'd4 + 36'($urandom_range(0, 1) ? 0 : $urandom % dvs);
			end
			4: begin
				dvs = $urandom_range(0, 3);
				dvd = w;
			end
			default: begin
				dvs = $urandom | 32'h80000000;
				dvd = 36'($urandom) + 36'($urandom_range(0, 15)) * 36'(dvs);
			end
		endcase
		send_item(logic'($urandom_range(1)), dvd, dvs);
	endtask

	// Receiver: random stall, or forced stall while hold_off is set.
	always @(posedge clk) begin
		if (hold_off)
			out_stall <= 1'b1;
		else
			out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// Check every result transfer.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(out_data);
	end

	// Watchdog: cycles with no transfer on either side.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", idle_cycles);
			$display("fractional_divider_parameter_calc_unit regression: fail");
			$finish;
		end
	end

	// Long receiver hold-off counted in its own process.
	task automatic receiver_hold(int unsigned cycles);
		hold_off = 1'b1;
		repeat (cycles)
			@(posedge clk);
		hold_off = 1'b0;
	endtask

	initial begin
		repeat (9)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: field extremes, both opcodes, quotient four, zero divisor,
		// quotient overflow, wide denominators, integer mode.
		send_item(OP_FEEDBACK, 36'd0, 32'd1);
		send_item(OP_OUTPUT, 36'd0, 32'd0);
		send_item(OP_FEEDBACK, 36'hFFFFFFFFF, 32'd0);
		send_item(OP_OUTPUT, 36'hFFFFFFFFF, 32'd1);
		send_item(OP_FEEDBACK, 36'hFFFFFFFFF, 32'hFFFFFFFF);
		send_item(OP_OUTPUT, 36'hFFFFFFFFF, 32'hFFFFFFFF);
		send_item(OP_OUTPUT, 36'd400, 32'd100);
		send_item(OP_OUTPUT, 36'd401, 32'd100);
		send_item(OP_FEEDBACK, 36'd400, 32'd100);
		send_item(OP_OUTPUT, 36'h400000004, 32'd1);
		send_item(OP_OUTPUT, 36'd5, 32'd1);
		send_item(OP_FEEDBACK, 36'd900000000, 32'd25000000);
		send_item(OP_FEEDBACK, 36'd900000001, 32'd25000000);
		send_item(OP_FEEDBACK, 36'd800000000, 32'd1048575);
		send_item(OP_FEEDBACK, 36'd800000000, 32'd1048576);
		send_item(OP_OUTPUT, 36'd3141592653, 32'd1000000007);
		send_item(OP_OUTPUT, 36'h555555555, 32'hAAAAAAAA);
		send_item(OP_FEEDBACK, 36'hAAAAAAAAA, 32'h55555555);
		send_item(OP_FEEDBACK, 36'd4294967296, 32'd4294967295);
		send_item(OP_OUTPUT, 36'd17179869180, 32'd4294967295);
		send_item(OP_FEEDBACK, 36'd1, 32'hFFFFFFFF);

		// Sender pauses until every expected result has come.
		wait_drained();

		// Long receiver hold-off while the sender keeps offering.
		fork
			receiver_hold(3000);
		join_none
		repeat (20)
			send_random();

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS / 3) begin
				send_idle_pct = 65;
				recv_idle_pct = 24;
			end else if (i == 2 * RANDOM_ITEMS / 3) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			send_random();
		end

		wait_drained();
		repeat (2000)
			@(posedge clk);
		if (mismatch_count == 0 && sb.pending_params.size() == 0) begin
			$display("fractional_divider_parameter_calc_unit regression: pass");
		end else begin
			$display("fractional_divider_parameter_calc_unit regression: fail");
		end
		$finish;
	end

endmodule
